// ===== rtl/tlpt_pkg.sv =====
`timescale 1ns / 1ps

package tlpt_pkg;

   // Fixed geometry of the virtual address.
   localparam int unsigned IDX_W             = 10;
   localparam int unsigned OFF_W             = 12;
   localparam int unsigned ENTRIES_PER_TABLE = 1024;
   localparam int unsigned PTE_W             = 32;

   // Operation codes.
   localparam logic [1:0] OP_MAP       = 2'd0;
   localparam logic [1:0] OP_UNMAP     = 2'd1;
   localparam logic [1:0] OP_TRANSLATE = 2'd2;

   // Status codes.
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] virt_addr;
      logic [31:0] phys_addr;
      logic [9:0]  flags;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] translated_addr;
      logic        flush;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROOT,
      ST_LEAF
   } state_type;

endpackage

// ===== rtl/tlpt_ram.sv =====
`timescale 1ns / 1ps

module tlpt_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/two_level_page_table_manager_core.sv =====
`timescale 1ns / 1ps

// Two-level page table manager. Each request transaction maps, unmaps or translates one
// 32-bit virtual address (root index in bits 31..22, leaf index in bits 21..12) and returns
// exactly one response transaction. One request is handled at a time. A map, an unknown
// operation, or an unmap or translate whose root entry is invalid is finished in the root
// step (ST_ROOT), after which the next request can be accepted. An unmap or translate that
// finds a valid root entry also passes through the leaf step (ST_LEAF), whether or not the
// leaf turns out to be valid, since the root entry read in the root RAM must finish before
// the dependent leaf read. The response register lets a new request be accepted while the
// previous response waits. The new request then holds in its current step for as long as
// that response is not taken. After reset the block runs a clearing pass over the leaf RAM
// (clearing the root RAM along the way) and accepts no request until it is done.
module two_level_page_table_manager_core #(
   parameter int unsigned NUM_TABLES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tlpt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlpt_pkg::rsp_type rsp_payload
);

   import tlpt_pkg::*;

   localparam int unsigned TAB_W      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
   localparam int unsigned ROOT_W     = TAB_W + 1;
   localparam int unsigned LEAF_DEPTH = NUM_TABLES * ENTRIES_PER_TABLE;
   localparam int unsigned LEAF_AW    = $clog2(LEAF_DEPTH);
   localparam int unsigned CNT_W      = $clog2(NUM_TABLES + 1);

   state_type          state_ff, state_in;
   req_type            req_ff;
   logic [CNT_W-1:0]   next_free_ff, next_free_in;
   logic [LEAF_AW-1:0] clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic               out_free;
   logic               rsp_load;
   logic               alloc;

   logic               root_wr_en;
   logic [IDX_W-1:0]   root_wr_addr;
   logic [ROOT_W-1:0]  root_wr_data;
   logic [ROOT_W-1:0]  root_rd_data;
   logic               leaf_wr_en;
   logic [LEAF_AW-1:0] leaf_wr_addr;
   logic [PTE_W-1:0]   leaf_wr_data;
   logic               leaf_rd_en;
   logic [PTE_W-1:0]   leaf_rd_data;

   logic [IDX_W-1:0]   root_idx;
   logic [IDX_W-1:0]   leaf_idx;
   logic [OFF_W-1:0]   page_offset;
   logic               root_valid;
   logic [TAB_W-1:0]   root_table;
   logic [TAB_W-1:0]   new_table;
   logic [TAB_W-1:0]   sel_table;
   logic               pool_avail;
   logic [LEAF_AW-1:0] leaf_addr;
   logic [PTE_W-1:0]   pte_new;
   logic               is_lookup;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign root_idx    = req_ff.virt_addr[31:22];
   assign leaf_idx    = req_ff.virt_addr[21:12];
   assign page_offset = req_ff.virt_addr[11:0];

   assign root_valid = root_rd_data[ROOT_W-1];
   assign root_table = root_rd_data[TAB_W-1:0];
   assign new_table  = next_free_ff[TAB_W-1:0];
   assign pool_avail = (next_free_ff < CNT_W'(NUM_TABLES));
   assign sel_table  = root_valid ? root_table : new_table;
   assign leaf_addr  = LEAF_AW'({sel_table, leaf_idx});
   assign is_lookup  = req_ff.operation inside {OP_UNMAP, OP_TRANSLATE};

   // Leaf PTE: physical page number in bits 29..10, permission bits below, valid in bit 0.
   assign pte_new = {2'b00, req_ff.phys_addr[31:12], 10'd0}
                  | {22'd0, req_ff.flags}
                  | 32'd1;

   tlpt_ram #(
      .WIDTH (ROOT_W),
      .DEPTH (ENTRIES_PER_TABLE)
   ) u_root_ram (
      .clock   (clock),
      .wr_en   (root_wr_en),
      .wr_addr (root_wr_addr),
      .wr_data (root_wr_data),
      .rd_en   (accept),
      .rd_addr (req_payload.virt_addr[31:22]),
      .rd_data (root_rd_data)
   );

   tlpt_ram #(
      .WIDTH (PTE_W),
      .DEPTH (LEAF_DEPTH)
   ) u_leaf_ram (
      .clock   (clock),
      .wr_en   (leaf_wr_en),
      .wr_addr (leaf_wr_addr),
      .wr_data (leaf_wr_data),
      .rd_en   (leaf_rd_en),
      .rd_addr (leaf_addr),
      .rd_data (leaf_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LEAF_AW'(LEAF_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (out_free) begin
               state_in = (is_lookup && root_valid) ? ST_LEAF : ST_IDLE;
            end
         end
         ST_LEAF: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Memory accesses and the response. Outside the clearing pass, writes happen only together
   // with loading the response, so a stalled transaction never writes twice.
   always_comb begin
      root_wr_en   = 1'b0;
      root_wr_addr = root_idx;
      root_wr_data = {1'b1, new_table};
      leaf_wr_en   = 1'b0;
      leaf_wr_addr = leaf_addr;
      leaf_wr_data = pte_new;
      leaf_rd_en   = 1'b0;
      rsp_load     = 1'b0;
      alloc        = 1'b0;
      rsp_in       = '{status: STATUS_FAIL, translated_addr: 32'd0, flush: 1'b0};
      case (state_ff)
         ST_CLEAR: begin
            root_wr_en   = 1'b1;
            root_wr_addr = clr_ff[IDX_W-1:0];
            root_wr_data = '0;
            leaf_wr_en   = 1'b1;
            leaf_wr_addr = clr_ff;
            leaf_wr_data = '0;
         end
         ST_ROOT: begin
            if (out_free) begin
               case (req_ff.operation)
                  OP_MAP: begin
                     rsp_load = 1'b1;
                     if (root_valid || pool_avail) begin
                        leaf_wr_en    = 1'b1;
                        rsp_in.status = STATUS_OK;
                        if (!root_valid) begin
                           root_wr_en = 1'b1;
                           alloc      = 1'b1;
                        end
                     end
                  end
                  OP_UNMAP, OP_TRANSLATE: begin
                     if (root_valid) begin
                        leaf_rd_en = 1'b1;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  default: rsp_load = 1'b1;
               endcase
            end
         end
         ST_LEAF: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (leaf_rd_data[0]) begin
                  rsp_in.status = STATUS_OK;
                  if (req_ff.operation == OP_UNMAP) begin
                     leaf_wr_en   = 1'b1;
                     leaf_wr_data = '0;
                     rsp_in.flush = 1'b1;
                  end else begin
                     rsp_in.translated_addr = {leaf_rd_data[29:10], page_offset};
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign next_free_in = alloc ? next_free_ff + CNT_W'(1) : next_free_ff;
   assign clr_in       = (state_ff == ST_CLEAR) ? clr_ff + LEAF_AW'(1) : clr_ff;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         next_free_ff <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_free_ff <= next_free_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request accepted during the clearing pass");

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= CNT_W'(NUM_TABLES))
      else $error("table pool count exceeds the number of tables");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_ROOT))
      else $error("accepted transaction did not start the root lookup");

   a_flush_means_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.flush) |-> (rsp_ff.status == STATUS_OK)
                                         && (rsp_ff.translated_addr == 32'd0))
      else $error("flush raised on a failed or translating response");

   a_alloc_only_when_free: assert property (@(posedge clock) disable iff (reset)
      alloc |-> (pool_avail && !root_valid && rsp_load))
      else $error("table taken from an exhausted pool or over a valid root entry");
`endif

endmodule
